### rtl/tde_pkg.sv
`default_nettype none

package tde_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;

    // Field widths
    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 10;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;
    localparam int SX_W    = 10;
    localparam int SY_W    = 9;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    // Internal arithmetic widths
    localparam int RES_W  = $clog2(SCREEN_MAX);
    localparam int CNT_W  = (RES_W > 1) ? $clog2(RES_W) : 1;
    localparam int DIFF_W = VALUE_W + 1;
    localparam int NUM_W  = VALUE_W + RES_W;
    localparam int ALU_W  = NUM_W + 1;

    // Event types and codes
    localparam logic [TYPE_W-1:0] EV_SYN = TYPE_W'(0);
    localparam logic [TYPE_W-1:0] EV_KEY = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] EV_ABS = TYPE_W'(3);

    localparam logic [CODE_W-1:0] CODE_SYNC      = CODE_W'(0);
    localparam logic [CODE_W-1:0] ABS_X          = CODE_W'(0);
    localparam logic [CODE_W-1:0] ABS_Y          = CODE_W'(1);
    localparam logic [CODE_W-1:0] CODE_PRESSURE  = CODE_W'(24);
    localparam logic [CODE_W-1:0] CODE_TOUCH_KEY = CODE_W'(330);

    // Configuration register map and reset values
    typedef enum logic [CIDX_W-1:0] {
        CFG_X_LOW  = 2'd0,
        CFG_X_HIGH = 2'd1,
        CFG_Y_LOW  = 2'd2,
        CFG_Y_HIGH = 2'd3
    } cfg_reg_t;

    localparam logic signed [CFG_W-1:0] RST_X_LOW  = 32'sd0;
    localparam logic signed [CFG_W-1:0] RST_X_HIGH = 32'sd799;
    localparam logic signed [CFG_W-1:0] RST_Y_LOW  = 32'sd0;
    localparam logic signed [CFG_W-1:0] RST_Y_HIGH = 32'sd479;

    typedef enum logic [KIND_W-1:0] {
        KIND_DOWN = 2'd0,
        KIND_MOVE = 2'd1,
        KIND_UP   = 2'd2
    } touch_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_RANGE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } tde_state_t;

endpackage

`default_nettype wire

### rtl/tde_intf.sv
`default_nettype none

interface tde_event_if;
    logic                         valid;
    logic                         ready;
    logic [tde_pkg::TYPE_W-1:0]   event_type;
    logic [tde_pkg::CODE_W-1:0]   event_code;
    logic signed [tde_pkg::VALUE_W-1:0] event_value;

    modport source (output valid, output event_type, output event_code,
                    output event_value, input ready);
    modport sink   (input valid, input event_type, input event_code,
                    input event_value, output ready);
endinterface

interface tde_touch_if;
    logic                        valid;
    logic                        ready;
    logic [tde_pkg::KIND_W-1:0]  touch_kind;
    logic [tde_pkg::SX_W-1:0]    screen_x;
    logic [tde_pkg::SY_W-1:0]    screen_y;

    modport source (output valid, output touch_kind, output screen_x,
                    output screen_y, input ready);
    modport sink   (input valid, input touch_kind, input screen_x,
                    input screen_y, output ready);
endinterface

`default_nettype wire

### rtl/touch_event_decoder_top.sv
`default_nettype none
// Channel     Dir   Payload                                   Handshake
// event_in    in    event_type[5] event_code[10] value[32s]   valid/ready
// touch_out   out   touch_kind[2] screen_x[10] screen_y[9]    valid/ready
// cfg         in    cfg_index[2] cfg_data[32]                 cfg_we, no wait
//
// Steps: axis, key, ignored and silent sync requests finish in the idle state; a
// sync with a result takes each axis, X then Y, through offset, range and compare
// on the shared subtractor, then a multiply and one quotient bit a cycle on it.
// Reset: rst_n clears the touch state and loads the default raw ranges.
// Stalls: the result sits in an output register; a later result waits in the
// done state until that register frees up, and event_in is not ready until then.

module touch_event_decoder_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tde_event_if.sink                        event_in,
    tde_touch_if.source                      touch_out,
    input  wire logic                        cfg_we,
    input  wire logic [tde_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [tde_pkg::CFG_W-1:0]   cfg_data
);
    import tde_pkg::*;

    localparam logic [RES_W-1:0] TOP_X = RES_W'(SCREEN_WIDTH - 1);
    localparam logic [RES_W-1:0] TOP_Y = RES_W'(SCREEN_HEIGHT - 1);

    // Control state
    tde_state_t state_reg, state_next;
    logic       axis_y_reg, axis_y_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Touch tracking state
    logic signed [VALUE_W-1:0] held_x_reg, held_x_next;
    logic signed [VALUE_W-1:0] held_y_reg, held_y_next;
    logic position_seen_reg, position_seen_next;
    logic touching_reg, touching_next;
    logic was_touching_reg, was_touching_next;
    logic moved_reg, moved_next;

    // Raw range configuration
    logic signed [CFG_W-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;

    // Datapath work registers
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [DIFF_W-1:0] range_reg, range_next;
    logic [NUM_W-1:0]         rem_reg, rem_next;
    logic [RES_W-1:0]         q_reg, q_next;
    logic [RES_W-1:0]         res_x_reg, res_x_next;
    logic [RES_W-1:0]         res_y_reg, res_y_next;
    touch_kind_t              kind_reg, kind_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    touch_kind_t       out_kind_reg, out_kind_next;
    logic [SX_W-1:0]   out_x_reg, out_x_next;
    logic [SY_W-1:0]   out_y_reg, out_y_next;

    // Shared subtractor
    logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;

    logic                      in_acc;
    logic                      out_acc;
    logic                      touch_eff;
    logic signed [VALUE_W-1:0] cur_v;
    logic signed [CFG_W-1:0]   cur_lo, cur_hi;
    logic [RES_W-1:0]          top_w;
    logic signed [VALUE_W-1:0] top_ext;
    logic                      range_empty;
    logic                      res_load;
    logic [RES_W-1:0]          res_val;

    assign in_acc  = event_in.valid && event_in.ready;
    assign out_acc = touch_out.valid && touch_out.ready;

    assign event_in.ready       = (state_reg == ST_IDLE);
    assign touch_out.valid      = out_valid_reg;
    assign touch_out.touch_kind = out_kind_reg;
    assign touch_out.screen_x   = out_x_reg;
    assign touch_out.screen_y   = out_y_reg;

    // Select the axis being scaled
    assign cur_v   = axis_y_reg ? held_y_reg : held_x_reg;
    assign cur_lo  = axis_y_reg ? y_low_reg : x_low_reg;
    assign cur_hi  = axis_y_reg ? y_high_reg : x_high_reg;
    assign top_w   = axis_y_reg ? TOP_Y : TOP_X;
    assign top_ext = $signed(VALUE_W'(top_w));
    assign range_empty = range_reg[DIFF_W-1] || (range_reg == '0);

    // A release followed by movement counts as a press
    assign touch_eff = touching_reg || (moved_reg && !was_touching_reg);

    // One subtractor serves offsets, range, compare and every divide step
    always_comb
    begin
        case (state_reg)
            ST_DIFF:
            begin
                alu_a = ALU_W'(cur_v);
                alu_b = ALU_W'(cur_lo);
            end
            ST_RANGE:
            begin
                alu_a = ALU_W'(cur_hi);
                alu_b = ALU_W'(cur_lo);
            end
            ST_CHECK:
            begin
                alu_a = ALU_W'(diff_reg);
                alu_b = ALU_W'(range_reg);
            end
            ST_DIV:
            begin
                alu_a = $signed({1'b0, rem_reg});
                alu_b = $signed({1'b0, NUM_W'(range_reg[VALUE_W-1:0]) << cnt_reg});
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
        alu_y = alu_a - alu_b;
    end

    always_comb
    begin
        state_next         = state_reg;
        axis_y_next        = axis_y_reg;
        cnt_next           = cnt_reg;
        held_x_next        = held_x_reg;
        held_y_next        = held_y_reg;
        position_seen_next = position_seen_reg;
        touching_next      = touching_reg;
        was_touching_next  = was_touching_reg;
        moved_next         = moved_reg;
        diff_next          = diff_reg;
        range_next         = range_reg;
        rem_next           = rem_reg;
        q_next             = q_reg;
        kind_next          = kind_reg;
        res_load           = 1'b0;
        res_val            = '0;
        out_valid_next     = out_valid_reg && !out_acc;
        out_kind_next      = out_kind_reg;
        out_x_next         = out_x_reg;
        out_y_next         = out_y_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (event_in.event_type == EV_ABS)
                    begin
                        if (event_in.event_code == ABS_X)
                        begin
                            held_x_next        = event_in.event_value;
                            position_seen_next = 1'b1;
                            moved_next         = 1'b1;
                        end
                        else if (event_in.event_code == ABS_Y)
                        begin
                            held_y_next        = event_in.event_value;
                            position_seen_next = 1'b1;
                            moved_next         = 1'b1;
                        end
                        else if (event_in.event_code == CODE_PRESSURE)
                        begin
                            touching_next = (event_in.event_value > 0);
                        end
                    end
                    else if (event_in.event_type == EV_KEY &&
                             event_in.event_code == CODE_TOUCH_KEY)
                    begin
                        touching_next = (event_in.event_value != 0);
                    end
                    else if (event_in.event_type == EV_SYN &&
                             event_in.event_code == CODE_SYNC)
                    begin
                        touching_next = touch_eff;
                        if (!position_seen_reg)
                        begin
                            moved_next        = 1'b0;
                            was_touching_next = touch_eff;
                        end
                        else if (touch_eff && !was_touching_reg)
                        begin
                            // Press without movement: keep the history as is
                            if (moved_reg)
                            begin
                                kind_next         = KIND_DOWN;
                                moved_next        = 1'b0;
                                was_touching_next = touch_eff;
                                axis_y_next       = 1'b0;
                                state_next        = ST_DIFF;
                            end
                        end
                        else if (touch_eff && moved_reg)
                        begin
                            kind_next         = KIND_MOVE;
                            moved_next        = 1'b0;
                            was_touching_next = touch_eff;
                            axis_y_next       = 1'b0;
                            state_next        = ST_DIFF;
                        end
                        else if (!touch_eff && was_touching_reg)
                        begin
                            kind_next         = KIND_UP;
                            moved_next        = 1'b0;
                            was_touching_next = touch_eff;
                            axis_y_next       = 1'b0;
                            state_next        = ST_DIFF;
                        end
                        else
                        begin
                            moved_next        = 1'b0;
                            was_touching_next = touch_eff;
                        end
                    end
                end
            end
            ST_DIFF:
            begin
                diff_next  = alu_y[DIFF_W-1:0];
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                range_next = alu_y[DIFF_W-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (range_empty)
                begin
                    // Empty range: clamp the raw value itself
                    res_load = 1'b1;
                    if (cur_v[VALUE_W-1])
                        res_val = '0;
                    else if (cur_v > top_ext)
                        res_val = top_w;
                    else
                        res_val = cur_v[RES_W-1:0];
                end
                else if (diff_reg[DIFF_W-1])
                begin
                    res_load = 1'b1;
                    res_val  = '0;
                end
                else if (!alu_y[ALU_W-1])
                begin
                    // Offset at or past the range: quotient is at least top
                    res_load = 1'b1;
                    res_val  = top_w;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                rem_next   = NUM_W'(diff_reg[VALUE_W-1:0]) * NUM_W'(top_w);
                q_next     = '0;
                cnt_next   = CNT_W'(RES_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!alu_y[ALU_W-1])
                begin
                    rem_next         = alu_y[NUM_W-1:0];
                    q_next[cnt_reg]  = 1'b1;
                end
                if (cnt_reg == '0)
                begin
                    res_load = 1'b1;
                    res_val  = q_next;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_acc)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_x_next     = SX_W'(res_x_reg);
                    out_y_next     = SY_W'(res_y_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Store the axis result and advance to the next axis or finish
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        if (res_load)
        begin
            if (axis_y_reg)
            begin
                res_y_next = res_val;
                state_next = ST_DONE;
            end
            else
            begin
                res_x_next  = res_val;
                axis_y_next = 1'b1;
                state_next  = ST_DIFF;
            end
        end
    end

    // Control and touch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            axis_y_reg        <= 1'b0;
            cnt_reg           <= '0;
            held_x_reg        <= '0;
            held_y_reg        <= '0;
            position_seen_reg <= 1'b0;
            touching_reg      <= 1'b0;
            was_touching_reg  <= 1'b0;
            moved_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            axis_y_reg        <= axis_y_next;
            cnt_reg           <= cnt_next;
            held_x_reg        <= held_x_next;
            held_y_reg        <= held_y_next;
            position_seen_reg <= position_seen_next;
            touching_reg      <= touching_next;
            was_touching_reg  <= was_touching_next;
            moved_reg         <= moved_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Raw range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= RST_X_LOW;
            x_high_reg <= RST_X_HIGH;
            y_low_reg  <= RST_Y_LOW;
            y_high_reg <= RST_Y_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_X_LOW:  x_low_reg  <= cfg_data;
                CFG_X_HIGH: x_high_reg <= cfg_data;
                CFG_Y_LOW:  y_low_reg  <= cfg_data;
                CFG_Y_HIGH: y_high_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        range_reg    <= range_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        kind_reg     <= kind_next;
        out_kind_reg <= out_kind_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
    end

`ifndef SYNTHESIS
    // Scaled coordinates never exceed the screen edge
    a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (res_x_reg <= TOP_X && res_y_reg <= TOP_Y))
        else $error("scaled coordinate beyond screen edge");

    // A result appears only from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output valid raised outside done state");

    // The divide runs only on a positive range and non-negative offset
    a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (!range_reg[DIFF_W-1] && !diff_reg[DIFF_W-1]
                                   && range_reg != '0))
        else $error("divide started with invalid operands");
`endif

endmodule

`default_nettype wire

### sim/touch_event_decoder_top_test.sv
module touch_event_decoder_top_test;

    import tde_pkg::*;

    // Codes that the decoder has to ignore.
    localparam logic [TYPE_W-1:0] EV_OTHER  = TYPE_W'(31);
    localparam logic [CODE_W-1:0] ABS_OTHER = CODE_W'(2);
    localparam logic [CODE_W-1:0] SYN_OTHER = CODE_W'(5);

    localparam int SETTLE_CYCLES = 40;      // margin beyond the longest sync report
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        touch_kind_t          kind;
        logic [SX_W-1:0]      x;
        logic [SY_W-1:0]      y;
    } touch_t;

    // Tracks the decoder state and the touch reports still owed by the block.
    class touch_tracker;
        logic signed [CFG_W-1:0]   x_low;
        logic signed [CFG_W-1:0]   x_high;
        logic signed [CFG_W-1:0]   y_low;
        logic signed [CFG_W-1:0]   y_high;
        logic signed [VALUE_W-1:0] held_x;
        logic signed [VALUE_W-1:0] held_y;
        bit                        position_seen;
        bit                        touching;
        bit                        was_touching;
        bit                        moved;
        touch_t                    due_touches[$];
        int                        faults;

        function new();
            x_low         = RST_X_LOW;
            x_high        = RST_X_HIGH;
            y_low         = RST_Y_LOW;
            y_high        = RST_Y_HIGH;
            held_x        = '0;
            held_y        = '0;
            position_seen = 1'b0;
            touching      = 1'b0;
            was_touching  = 1'b0;
            moved         = 1'b0;
            faults        = 0;
        endfunction

        function void set_range(cfg_reg_t idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_X_LOW:  x_low  = d;
                CFG_X_HIGH: x_high = d;
                CFG_Y_LOW:  y_low  = d;
                CFG_Y_HIGH: y_high = d;
                default:    ;
            endcase
        endfunction

        function longint map_axis(longint v, longint lo, longint hi, longint top);
            longint r;
            longint num;
            if (hi <= lo)
                r = v;
            else
            begin
                num = (v - lo) * top;
                if (num < 0)
                    return 0;
                r = num / (hi - lo);
            end
            if (r < 0)
                r = 0;
            if (r > top)
                r = top;
            return r;
        endfunction

        function void note_event(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                                 logic signed [VALUE_W-1:0] v);
            touch_t due;
            if (t == EV_ABS)
            begin
                if (c == ABS_X)
                begin
                    held_x        = v;
                    position_seen = 1'b1;
                    moved         = 1'b1;
                end
                else if (c == ABS_Y)
                begin
                    held_y        = v;
                    position_seen = 1'b1;
                    moved         = 1'b1;
                end
                else if (c == CODE_PRESSURE)
                    touching = (v > 0);
                return;
            end
            if (t == EV_KEY && c == CODE_TOUCH_KEY)
            begin
                touching = (v != 0);
                return;
            end
            if (t != EV_SYN || c != CODE_SYNC)
                return;

            if (moved && !touching && !was_touching)
                touching = 1'b1;
            if (!position_seen)
            begin
                moved        = 1'b0;
                was_touching = touching;
                return;
            end

            if (touching && !was_touching)
            begin
                if (!moved)
                    return;
                due.kind = KIND_DOWN;
            end
            else if (touching && moved)
                due.kind = KIND_MOVE;
            else if (!touching && was_touching)
                due.kind = KIND_UP;
            else
            begin
                moved        = 1'b0;
                was_touching = touching;
                return;
            end

            moved        = 1'b0;
            was_touching = touching;
            due.x = SX_W'(map_axis(held_x, x_low, x_high, SCREEN_WIDTH - 1));
            due.y = SY_W'(map_axis(held_y, y_low, y_high, SCREEN_HEIGHT - 1));
            due_touches.push_back(due);
        endfunction

        function void note_fault(string what);
            if (faults < 10)
                $display("[%0t] touch mismatch: %s", $time, what);
            faults++;
        endfunction

        function void check_touch(logic [KIND_W-1:0] k, logic [SX_W-1:0] sx,
                                  logic [SY_W-1:0] sy);
            touch_t due;
            if (due_touches.size() == 0)
            begin
                note_fault($sformatf("unexpected kind %0d x %0d y %0d", k, sx, sy));
                return;
            end
            due = due_touches.pop_front();
            if (k !== due.kind || sx !== due.x || sy !== due.y)
                note_fault($sformatf("expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
                                     due.kind, due.x, due.y, k, sx, sy));
        endfunction

        function int outstanding();
            return due_touches.size();
        endfunction

        function void flag_leftovers();
            touch_t due;
            while (due_touches.size() != 0)
            begin
                due = due_touches.pop_front();
                note_fault($sformatf("kind %0d never reported", due.kind));
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    tde_event_if ev();
    tde_touch_if tch();

    touch_tracker board;
    bit           steady;       // no gaps on either side while set
    bit           hold_out;     // receiver holds ready low for HOLD_CYCLES
    int           useful;       // requests that touch decoder state

    touch_event_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_in  (ev),
        .touch_out (tch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = ~clk;
    end

    // Mostly back-to-back, now and then a short pause, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit has_effect(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c);
        return (t == EV_ABS && (c == ABS_X || c == ABS_Y || c == CODE_PRESSURE)) ||
               (t == EV_KEY && c == CODE_TOUCH_KEY) ||
               (t == EV_SYN && c == CODE_SYNC);
    endfunction

    // Coordinates: mostly inside the configured raw range, some at its edges,
    // some anywhere in the 32-bit space.
    function automatic logic [VALUE_W-1:0] pick_coord(longint lo, longint hi);
        longint unsigned span;
        longint unsigned draw;
        int              roll;
        roll = $urandom_range(0, 9);
        draw = {$urandom, $urandom};
        if (roll < 7 && hi > lo)
        begin
            span = hi - lo + 1;
            return VALUE_W'(lo + longint'(draw % span));
        end
        if (roll == 7)
            return VALUE_W'(lo + $urandom_range(0, 4) - 2);
        if (roll == 8)
            return VALUE_W'(hi + $urandom_range(0, 4) - 2);
        return draw[VALUE_W-1:0];
    endfunction

    // Key state or pressure: released, pressed, negative, or anything.
    function automatic logic [VALUE_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return '0;
        if (roll < 7)
            return VALUE_W'(1);
        if (roll < 8)
            return '1;
        return $urandom;
    endfunction

    // Offer one request after a random gap and hold it until accepted.
    // Enter and leave on a falling edge.
    task automatic send_event(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                              logic [VALUE_W-1:0] v);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            ev.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev.valid       <= 1'b1;
        ev.event_type  <= t;
        ev.event_code  <= c;
        ev.event_value <= v;
        @(posedge clk);
        while (!ev.ready)
            @(posedge clk);
        board.note_event(t, c, v);
        if (has_effect(t, c))
            useful++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every owed touch report, then let the block settle.
    task automatic await_quiet();
        int waited;
        waited = 0;
        ev.valid <= 1'b0;
        while (board.outstanding() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all four raw range registers on consecutive cycles; only call
    // this while the decoder is quiet.
    task automatic load_ranges(logic [CFG_W-1:0] xl, logic [CFG_W-1:0] xh,
                               logic [CFG_W-1:0] yl, logic [CFG_W-1:0] yh);
        logic [CFG_W-1:0] vals [4];
        cfg_reg_t         idx;
        vals = '{xl, xh, yl, yh};
        idx  = idx.first();
        repeat (4)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            board.set_range(idx, vals[idx]);
            @(negedge clk);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
    endtask

    // One report group: optional touch state, optional X and Y, then usually
    // a sync. About one group in eight is a single request of pure noise.
    task automatic random_report();
        if ($urandom_range(0, 99) < 12)
        begin
            send_event(TYPE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 1023)),
                       $urandom);
            return;
        end
        if ($urandom_range(0, 99) < 40)
        begin
            if ($urandom_range(0, 1))
                send_event(EV_KEY, CODE_TOUCH_KEY, pick_level());
            else
                send_event(EV_ABS, CODE_PRESSURE, pick_level());
        end
        if ($urandom_range(0, 99) < 60)
            send_event(EV_ABS, ABS_X, pick_coord(board.x_low, board.x_high));
        if ($urandom_range(0, 99) < 50)
            send_event(EV_ABS, ABS_Y, pick_coord(board.y_low, board.y_high));
        // A missing sync leaves the group open into the next one.
        if ($urandom_range(0, 99) < 90)
            send_event(EV_SYN, CODE_SYNC, $urandom);
    endtask

    task automatic run_reports(int target);
        while (useful < target)
            random_report();
    endtask

    // Load one random range setting: per axis, a random low bound and either a
    // span of 1 to 5000 above it or an arbitrary high bound anywhere in the 32-bit space.
    task automatic load_random_ranges();
        logic [CFG_W-1:0] xl;
        logic [CFG_W-1:0] yl;
        xl = $urandom;
        yl = $urandom;
        load_ranges(xl, $urandom_range(0, 1) ? xl + $urandom_range(1, 5000) : $urandom,
                    yl, $urandom_range(0, 1) ? yl + $urandom_range(1, 5000) : $urandom);
    endtask

    // Sample accepted touch reports on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && tch.valid && tch.ready)
            board.check_touch(tch.touch_kind, tch.screen_x, tch.screen_y);
    end

    // Receiver: random stalls of mixed length, plus one long hold-off on request.
    initial
    begin
        int stall;
        stall     = 0;
        tch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                tch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
            end
            else if (stall > 0)
            begin
                tch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = steady ? 0 : pick_gap();
                tch.ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    initial
    begin
        board          = new();
        steady         = 1'b0;
        hold_out       = 1'b0;
        useful         = 0;
        rst_n          = 1'b0;
        ev.valid       = 1'b0;
        ev.event_type  = EV_SYN;
        ev.event_code  = CODE_SYNC;
        ev.event_value = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_X_LOW;
        cfg_data       = '0;

        // Hold reset, then release it away from the rising edge.
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part on the reset ranges.
        // Sync reports before any coordinate was seen must stay silent,
        // whether the finger is up or down.
        send_event(EV_SYN, CODE_SYNC, '0);
        send_event(EV_KEY, CODE_TOUCH_KEY, VALUE_W'(1));
        send_event(EV_SYN, CODE_SYNC, '0);
        send_event(EV_KEY, CODE_TOUCH_KEY, '0);
        send_event(EV_SYN, CODE_SYNC, '0);
        // A position change while released counts as a press: DOWN at the origin.
        send_event(EV_ABS, ABS_X, '0);
        send_event(EV_ABS, ABS_Y, '0);
        send_event(EV_SYN, CODE_SYNC, '0);
        // MOVE to the far corner, then to the 32-bit extremes, which clamp.
        send_event(EV_ABS, ABS_X, VALUE_W'(799));
        send_event(EV_ABS, ABS_Y, VALUE_W'(479));
        send_event(EV_SYN, CODE_SYNC, '0);
        send_event(EV_ABS, ABS_X, 32'h7fff_ffff);
        send_event(EV_ABS, ABS_Y, 32'h8000_0000);
        send_event(EV_SYN, CODE_SYNC, '1);
        // Release gives UP.
        send_event(EV_KEY, CODE_TOUCH_KEY, '0);
        send_event(EV_SYN, CODE_SYNC, '0);
        // Pressure alone presses without movement: no report, twice over,
        // until a coordinate arrives and the DOWN goes out.
        send_event(EV_ABS, CODE_PRESSURE, VALUE_W'(5));
        send_event(EV_SYN, CODE_SYNC, '0);
        send_event(EV_SYN, CODE_SYNC, '0);
        send_event(EV_ABS, ABS_X, VALUE_W'(400));
        send_event(EV_SYN, CODE_SYNC, '0);
        // Negative pressure releases; the ignored codes must not disturb state.
        send_event(EV_ABS, CODE_PRESSURE, '1);
        send_event(EV_ABS, ABS_OTHER, $urandom);
        send_event(EV_OTHER, CODE_W'(1023), '1);
        send_event(EV_SYN, SYN_OTHER, $urandom);
        send_event(EV_SYN, CODE_SYNC, '0);
        // Sync with nothing new: silent. Then a negative key value presses.
        send_event(EV_SYN, CODE_SYNC, '0);
        send_event(EV_KEY, CODE_TOUCH_KEY, 32'hffff_fffb);
        send_event(EV_ABS, ABS_Y, VALUE_W'(100));
        send_event(EV_SYN, CODE_SYNC, '0);

        // Random reports on the reset ranges.
        run_reports(130);

        // Widest possible ranges. Midway, hold the receiver off for a long
        // stretch while the sender keeps pushing position reports, so the output
        // register and the done state fill and event_in stalls.
        await_quiet();
        load_ranges(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        run_reports(180);
        hold_out = 1'b1;
        send_event(EV_KEY, CODE_TOUCH_KEY, VALUE_W'(1));
        repeat (20)
        begin
            send_event(EV_ABS, ABS_X, pick_coord(board.x_low, board.x_high));
            send_event(EV_SYN, CODE_SYNC, $urandom);
        end
        run_reports(250);

        // Empty ranges: one equal pair and one inverted pair, so the raw value
        // is clamped directly. Pause the sender halfway until all reports are in.
        await_quiet();
        load_ranges(32'd100, 32'd100, 32'd500, -32'sd500);
        run_reports(300);
        await_quiet();
        run_reports(350);

        // Smallest nonempty ranges, with no gaps on either side.
        await_quiet();
        load_ranges('0, 32'd1, '1, '0);
        steady = 1'b1;
        run_reports(430);
        steady = 1'b0;

        // Random ranges.
        await_quiet();
        load_random_ranges();
        run_reports(510);
        await_quiet();
        load_random_ranges();
        run_reports(560);

        // Back to the reset ranges.
        await_quiet();
        load_ranges(RST_X_LOW, RST_X_HIGH, RST_Y_LOW, RST_Y_HIGH);
        run_reports(610);

        await_quiet();
        board.flag_leftovers();
        if (board.faults == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #(12 * 1000000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
